// ===== rtl/stl_pkg.sv =====
package stl_pkg;

  localparam int MaxTokenLenDefault = 128;

  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_text;
  } stl_in_t;

  typedef struct packed {
    logic        is_token;
    logic [5:0]  token_type;
    logic [15:0] line_number;
    logic [15:0] column;
    logic [7:0]  value_byte;
    logic [7:0]  value_length;
    logic        last;
  } stl_out_t;

  // lexer modes
  localparam logic [4:0] M_IDLE     = 5'd0;
  localparam logic [4:0] M_WORD     = 5'd1;
  localparam logic [4:0] M_INT      = 5'd2;
  localparam logic [4:0] M_FRAC     = 5'd3;
  localparam logic [4:0] M_STR      = 5'd4;
  localparam logic [4:0] M_STR_ESC  = 5'd5;
  localparam logic [4:0] M_CH_OPEN  = 5'd6;
  localparam logic [4:0] M_CH_ESC   = 5'd7;
  localparam logic [4:0] M_CH_CLOSE = 5'd8;
  localparam logic [4:0] M_EQ       = 5'd9;
  localparam logic [4:0] M_BANG     = 5'd10;
  localparam logic [4:0] M_LT       = 5'd11;
  localparam logic [4:0] M_GT       = 5'd12;
  localparam logic [4:0] M_AMP      = 5'd13;
  localparam logic [4:0] M_BAR      = 5'd14;
  localparam logic [4:0] M_SLASH    = 5'd15;
  localparam logic [4:0] M_COMMENT  = 5'd16;

  // token types
  localparam logic [5:0] T_EOF = 6'd0;
  localparam logic [5:0] T_NUMBER = 6'd1;
  localparam logic [5:0] T_ID = 6'd2;
  localparam logic [5:0] T_STRING = 6'd11;
  localparam logic [5:0] T_CHAR = 6'd12;
  localparam logic [5:0] T_ASSIGN = 6'd13;
  localparam logic [5:0] T_EQ = 6'd14;
  localparam logic [5:0] T_NE = 6'd15;
  localparam logic [5:0] T_GT = 6'd16;
  localparam logic [5:0] T_GE = 6'd17;
  localparam logic [5:0] T_LT = 6'd18;
  localparam logic [5:0] T_LE = 6'd19;
  localparam logic [5:0] T_AND = 6'd20;
  localparam logic [5:0] T_OR = 6'd21;
  localparam logic [5:0] T_COMMENT = 6'd22;
  localparam logic [5:0] T_DIV = 6'd23;
  localparam logic [5:0] T_LPAREN = 6'd24;
  localparam logic [5:0] T_ERR = 6'd35;

  localparam int NumKw = 10;

  // keyword byte at position pos, 0 past its end
  function automatic logic [7:0] kw_char(input int k, input logic [2:0] pos);
    logic [55:0] s;
    case (k)
      0: s = {"ah", 40'd0};
      1: s = {"beg", 32'd0};
      2: s = {"boo", 32'd0};
      3: s = {"if", 40'd0};
      4: s = {"else", 24'd0};
      5: s = {"while", 16'd0};
      6: s = {"return", 8'd0};
      7: s = {"int", 32'd0};
      8: s = {"char", 24'd0};
      default: s = {"void", 24'd0};
    endcase
    kw_char = s[55 - 8 * pos -: 8];
  endfunction

  function automatic logic [2:0] kw_len(input int k);
    case (k)
      0, 3: kw_len = 3'd2;
      1, 2, 7: kw_len = 3'd3;
      4, 8, 9: kw_len = 3'd4;
      5: kw_len = 3'd5;
      default: kw_len = 3'd6;
    endcase
  endfunction

  function automatic logic [5:0] kw_type(input int k);
    case (k)
      0: kw_type = 6'd4;
      1: kw_type = 6'd5;
      2: kw_type = 6'd6;
      3: kw_type = 6'd7;
      4: kw_type = 6'd8;
      5: kw_type = 6'd9;
      6: kw_type = 6'd10;
      default: kw_type = 6'd3;
    endcase
  endfunction

  typedef struct packed {
    logic        valid;
    logic        is_token;
    logic [5:0]  token_type;
    logic [15:0] column;
    logic [7:0]  value_byte;
    logic [7:0]  value_length;
  } stl_res_t;

endpackage

// ===== rtl/source_text_lexer_core.sv =====
// Streaming lexer for a small C-like language.
// Input channel (in_valid/in_ready/in_data): one source byte per word, or an
// end-of-text mark that flushes the pending token and emits EOF (error if open).
// Output channel (out_valid/out_ready/out_data): value bytes of a token, then
// its token record; the last result of each input word carries last.
// Each input byte is decoded against the lexer state and its up to two
// results are loaded into a three-entry output queue; the first result is
// valid in the cycle after acceptance. One byte per cycle is sustained while
// each byte yields at most one result and the receiver is ready; a byte with
// two results holds the input while the queue drains (one result per cycle).
// Reset (rst_n low, synchronous) returns to line 1, column 0, idle, and
// clears the halt. After an error token the block swallows all input with no
// result until reset. If the receiver stalls, the queue holds and in_ready
// drops once the queue cannot take the next word's results.
module source_text_lexer_core import stl_pkg::*; #(
  parameter int MAX_TOKEN_LEN = MaxTokenLenDefault
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  stl_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output stl_out_t out_data
);
  localparam int LenW = $clog2(MAX_TOKEN_LEN + 1);

  logic [4:0]       mode_r, mode_nxt;
  logic [15:0]      line_r, line_nxt;
  logic [15:0]      col_r, col_nxt;
  logic [15:0]      tcol_r, tcol_nxt;
  logic [LenW-1:0]  len_r, len_nxt;
  logic [NumKw-1:0] cand_r, cand_nxt;
  logic [7:0]       chv_r, chv_nxt;
  logic             halt_r, halt_nxt;

  logic             can_load, acc;
  stl_res_t         res [3];
  logic [1:0]       nres;
  logic [NumKw-1:0] cand_f;
  logic [5:0]       wtype;
  logic [NumKw-1:0] kw_in;
  logic [LenW-1:0]  kw_len_in;
  logic [NumKw-1:0] start_f;
  logic [5:0]       start_wt;
  logic [7:0]       c;
  logic [7:0]       vl;

  // no word is taken while reset is held
  assign in_ready = can_load && rst_n;
  assign acc = in_valid && in_ready;
  assign c = in_data.ch;
  assign vl = (len_r > LenW'(255)) ? 8'd255 : 8'(len_r);

  // filter for a word in progress and for a fresh word
  assign kw_in = cand_r;
  assign kw_len_in = len_r;
  stl_kw_match #(.LenW(LenW)) u_kw (
    .cand(kw_in), .len(kw_len_in), .ch(c), .cand_filt(cand_f), .word_type(wtype)
  );
  stl_kw_match #(.LenW(LenW)) u_kw0 (
    .cand({NumKw{1'b1}}), .len('0), .ch(c), .cand_filt(start_f), .word_type(start_wt)
  );

  function automatic logic is_dig(input logic [7:0] x);
    is_dig = (x >= "0") && (x <= "9");
  endfunction
  function automatic logic is_alp(input logic [7:0] x);
    is_alp = ((x >= "a") && (x <= "z")) || ((x >= "A") && (x <= "Z")) || (x == "_");
  endfunction
  function automatic logic [7:0] unesc(input logic [7:0] x);
    unesc = (x == "n") ? 8'd10 : (x == "t") ? 8'd9 : x;
  endfunction

  always_comb begin
    logic again, nl, hlt;
    logic [15:0] tc;
    again = 1'b0;
    nl = 1'b0;
    hlt = 1'b0;
    tc = tcol_r;
    mode_nxt = mode_r;
    line_nxt = line_r;
    col_nxt = col_r;
    tcol_nxt = tcol_r;
    len_nxt = len_r;
    cand_nxt = cand_r;
    chv_nxt = chv_r;
    halt_nxt = halt_r;
    for (int i = 0; i < 3; i++) res[i] = '0;
    nres = 2'd0;

    if (in_data.end_of_text) begin
      case (mode_r)
        M_WORD: begin
          res[0] = '{1'b1, 1'b1, wtype, tcol_r, 8'd0, vl};
          nres = 2'd1;
        end
        M_INT, M_FRAC: begin
          res[0] = '{1'b1, 1'b1, T_NUMBER, tcol_r, 8'd0, vl};
          nres = 2'd1;
        end
        M_EQ: begin res[0] = '{1'b1, 1'b1, T_ASSIGN, tcol_r, 8'd0, 8'd0}; nres = 2'd1; end
        M_LT: begin res[0] = '{1'b1, 1'b1, T_LT, tcol_r, 8'd0, 8'd0}; nres = 2'd1; end
        M_GT: begin res[0] = '{1'b1, 1'b1, T_GT, tcol_r, 8'd0, 8'd0}; nres = 2'd1; end
        M_SLASH: begin res[0] = '{1'b1, 1'b1, T_DIV, tcol_r, 8'd0, 8'd0}; nres = 2'd1; end
        M_BANG, M_AMP, M_BAR, M_STR, M_STR_ESC, M_CH_OPEN, M_CH_ESC, M_CH_CLOSE: begin
          res[0] = '{1'b1, 1'b1, T_ERR, tcol_r, 8'd0, 8'd0};
          nres = 2'd1;
          hlt = 1'b1;
        end
        default: ;
      endcase
      if (!hlt) begin
        res[nres] = '{1'b1, 1'b1, T_EOF, col_r, 8'd0, 8'd0};
        mode_nxt = M_IDLE;
        line_nxt = 16'd1;
        col_nxt = '0;
        tcol_nxt = '0;
        len_nxt = '0;
        cand_nxt = '1;
        chv_nxt = '0;
      end else begin
        halt_nxt = 1'b1;
      end
    end else begin
      case (mode_r)
        M_IDLE: again = 1'b1;
        M_WORD: begin
          if (is_alp(c) || is_dig(c)) begin
            cand_nxt = cand_f;
            if (len_r >= LenW'(MAX_TOKEN_LEN)) begin
              res[0] = '{1'b1, 1'b1, T_ERR, tcol_r, 8'd0, 8'd0}; hlt = 1'b1;
            end else begin
              res[0] = '{1'b1, 1'b0, 6'd0, tcol_r, c, 8'd0}; len_nxt = len_r + 1'b1;
            end
            nres = 2'd1;
          end else begin
            res[0] = '{1'b1, 1'b1, wtype, tcol_r, 8'd0, vl};
            nres = 2'd1; mode_nxt = M_IDLE; again = 1'b1;
          end
        end
        M_INT, M_FRAC, M_STR, M_STR_ESC: begin
          logic addv, close;
          logic [7:0] b;
          addv = 1'b0; close = 1'b0; b = c;
          case (mode_r)
            M_INT: if (is_dig(c)) addv = 1'b1;
                   else if (c == ".") begin addv = 1'b1; mode_nxt = M_FRAC; end
                   else close = 1'b1;
            M_FRAC: if (is_dig(c)) addv = 1'b1; else close = 1'b1;
            M_STR: if (c == "\"") begin
                     res[0] = '{1'b1, 1'b1, T_STRING, tcol_r, 8'd0, vl};
                     nres = 2'd1; mode_nxt = M_IDLE;
                   end else if (c == "\\") mode_nxt = M_STR_ESC;
                   else addv = 1'b1;
            default: begin mode_nxt = M_STR; addv = 1'b1; b = unesc(c); end
          endcase
          if (close) begin
            res[0] = '{1'b1, 1'b1, T_NUMBER, tcol_r, 8'd0, vl};
            nres = 2'd1; mode_nxt = M_IDLE; again = 1'b1;
          end
          if (addv) begin
            if (len_r >= LenW'(MAX_TOKEN_LEN)) begin
              res[0] = '{1'b1, 1'b1, T_ERR, tcol_r, 8'd0, 8'd0}; hlt = 1'b1;
            end else begin
              res[0] = '{1'b1, 1'b0, 6'd0, tcol_r, b, 8'd0}; len_nxt = len_r + 1'b1;
            end
            nres = 2'd1;
          end
        end
        M_CH_OPEN: begin
          if (c == "\\") mode_nxt = M_CH_ESC;
          else begin chv_nxt = c; mode_nxt = M_CH_CLOSE; end
        end
        M_CH_ESC: begin chv_nxt = unesc(c); mode_nxt = M_CH_CLOSE; end
        M_CH_CLOSE: begin
          if (c == "'") begin
            res[0] = '{1'b1, 1'b0, 6'd0, tcol_r, chv_r, 8'd0};
            res[1] = '{1'b1, 1'b1, T_CHAR, tcol_r, 8'd0, 8'd1};
            nres = 2'd2; mode_nxt = M_IDLE;
          end else begin
            res[0] = '{1'b1, 1'b1, T_ERR, tcol_r, 8'd0, 8'd0}; nres = 2'd1; hlt = 1'b1;
          end
        end
        M_EQ, M_LT, M_GT: begin
          logic [5:0] t1, t2;
          t1 = (mode_r == M_EQ) ? T_ASSIGN : (mode_r == M_LT) ? T_LT : T_GT;
          t2 = (mode_r == M_EQ) ? T_EQ : (mode_r == M_LT) ? T_LE : T_GE;
          nres = 2'd1; mode_nxt = M_IDLE;
          if (c == "=") res[0] = '{1'b1, 1'b1, t2, tcol_r, 8'd0, 8'd0};
          else begin res[0] = '{1'b1, 1'b1, t1, tcol_r, 8'd0, 8'd0}; again = 1'b1; end
        end
        M_BANG, M_AMP, M_BAR: begin
          logic [7:0] p;
          logic [5:0] t;
          p = (mode_r == M_BANG) ? "=" : (mode_r == M_AMP) ? "&" : "|";
          t = (mode_r == M_BANG) ? T_NE : (mode_r == M_AMP) ? T_AND : T_OR;
          nres = 2'd1;
          if (c == p) begin res[0] = '{1'b1, 1'b1, t, tcol_r, 8'd0, 8'd0}; mode_nxt = M_IDLE; end
          else begin res[0] = '{1'b1, 1'b1, T_ERR, tcol_r, 8'd0, 8'd0}; hlt = 1'b1; end
        end
        M_SLASH: begin
          nres = 2'd1;
          if (c == "/") begin
            res[0] = '{1'b1, 1'b1, T_COMMENT, tcol_r, 8'd0, 8'd0}; mode_nxt = M_COMMENT;
          end else begin
            res[0] = '{1'b1, 1'b1, T_DIV, tcol_r, 8'd0, 8'd0}; mode_nxt = M_IDLE; again = 1'b1;
          end
        end
        M_COMMENT: if (c == 8'd10) begin mode_nxt = M_IDLE; again = 1'b1; end
        default: begin mode_nxt = M_IDLE; again = 1'b1; end
      endcase

      // start a new token with this byte
      if (again && !hlt) begin
        tc = col_r;
        tcol_nxt = col_r;
        len_nxt = '0;
        if (c == 8'd10) nl = 1'b1;
        else if (c == " " || c == 8'd9) ;
        else if (is_dig(c) || is_alp(c)) begin
          mode_nxt = is_dig(c) ? M_INT : M_WORD;
          if (!is_dig(c)) cand_nxt = start_f;
          res[nres] = '{1'b1, 1'b0, 6'd0, tc, c, 8'd0};
          len_nxt = LenW'(1);
          nres = nres + 2'd1;
        end else begin
          case (c)
            "=": mode_nxt = M_EQ;
            "!": mode_nxt = M_BANG;
            "<": mode_nxt = M_LT;
            ">": mode_nxt = M_GT;
            "&": mode_nxt = M_AMP;
            "|": mode_nxt = M_BAR;
            "/": mode_nxt = M_SLASH;
            "\"": mode_nxt = M_STR;
            "'": mode_nxt = M_CH_OPEN;
            "(", ")", "{", "}", "[", "]", "+", "-", "*", ";", ",": begin
              logic [5:0] t;
              case (c)
                "(": t = T_LPAREN;
                ")": t = T_LPAREN + 6'd1;
                "{": t = T_LPAREN + 6'd2;
                "}": t = T_LPAREN + 6'd3;
                "[": t = T_LPAREN + 6'd4;
                "]": t = T_LPAREN + 6'd5;
                "+": t = T_LPAREN + 6'd6;
                "-": t = T_LPAREN + 6'd7;
                "*": t = T_LPAREN + 6'd8;
                ";": t = T_LPAREN + 6'd9;
                default: t = T_LPAREN + 6'd10;
              endcase
              res[nres] = '{1'b1, 1'b1, t, tc, 8'd0, 8'd0};
              nres = nres + 2'd1;
            end
            default: begin
              res[nres] = '{1'b1, 1'b1, T_ERR, tc, 8'd0, 8'd0};
              nres = nres + 2'd1;
              hlt = 1'b1;
            end
          endcase
        end
      end
      halt_nxt = hlt;
      if (nl) begin
        if (line_r != 16'hFFFF) line_nxt = line_r + 16'd1;
        col_nxt = '0;
      end else if (col_r != 16'hFFFF) begin
        col_nxt = col_r + 16'd1;
      end
    end
  end

  // queue with room for the results of one word
  stl_out_queue u_q (
    .clk(clk), .rst_n(rst_n), .load(acc && !halt_r),
    .r0(res[0]), .r1(res[1]), .r2(res[2]), .line0(line_r),
    .can_load(can_load), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      line_r <= 16'd1;
      col_r <= '0;
      tcol_r <= '0;
      len_r <= '0;
      cand_r <= '1;
      chv_r <= '0;
      halt_r <= 1'b0;
    end else if (acc && !halt_r) begin
      mode_r <= mode_nxt;
      line_r <= line_nxt;
      col_r <= col_nxt;
      tcol_r <= tcol_nxt;
      len_r <= len_nxt;
      cand_r <= cand_nxt;
      chv_r <= chv_nxt;
      halt_r <= halt_nxt;
    end
  end
endmodule

// ===== rtl/stl_kw_match.sv =====
// Keyword candidate filter and word type lookup
module stl_kw_match import stl_pkg::*; #(
  parameter int LenW = 8
) (
  input  logic [NumKw-1:0] cand,
  input  logic [LenW-1:0]  len,
  input  logic [7:0]       ch,
  output logic [NumKw-1:0] cand_filt,
  output logic [5:0]       word_type
);
  always_comb begin
    // drop candidates whose next byte differs
    for (int k = 0; k < NumKw; k++) begin
      cand_filt[k] = cand[k] && (len < LenW'(kw_len(k))) &&
                     (kw_char(k, len[2:0]) == ch);
    end
    word_type = T_ID;
    for (int k = NumKw - 1; k >= 0; k--) begin
      if (cand[k] && (LenW'(kw_len(k)) == len)) word_type = kw_type(k);
    end
  end
endmodule

// ===== rtl/stl_out_queue.sv =====
// Up to three results of a word; pops one per cycle while out_ready
module stl_out_queue import stl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  stl_res_t    r0,
  input  stl_res_t    r1,
  input  stl_res_t    r2,
  input  logic [15:0] line0,
  output logic        can_load,
  output logic        out_valid,
  input  logic        out_ready,
  output stl_out_t    out_data
);
  stl_res_t    q_r [3];
  stl_res_t    q_nxt [3];
  logic [15:0] line_r;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        pop;

  assign out_valid = (cnt_r != 2'd0);
  assign pop = out_valid && out_ready;
  // refill when empty or when the last entry pops this cycle
  assign can_load = (cnt_r == 2'd0) || (pop && cnt_r == 2'd1);

  always_comb begin
    q_nxt = q_r;
    cnt_nxt = cnt_r;
    if (pop) begin
      q_nxt[0] = q_r[1];
      q_nxt[1] = q_r[2];
      cnt_nxt = cnt_r - 2'd1;
    end
    if (load && can_load) begin
      q_nxt[0] = r0;
      q_nxt[1] = r1;
      q_nxt[2] = r2;
      cnt_nxt = 2'(r0.valid) + 2'(r1.valid) + 2'(r2.valid);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    if (load && can_load) line_r <= line0;
  end

  always_comb begin
    out_data.is_token = q_r[0].is_token;
    out_data.token_type = q_r[0].token_type;
    out_data.line_number = line_r;
    out_data.column = q_r[0].column;
    out_data.value_byte = q_r[0].value_byte;
    out_data.value_length = q_r[0].value_length;
    out_data.last = (cnt_r == 2'd1);
  end
endmodule
